[rtl/wildcard_byte_pattern_scanner_core_assert.svh]
// assertion macros for the pattern scanner rtl
// expects clk and rst_n in the scope of every use
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wbps check failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wbps check failed");

`endif

[rtl/wbps_pkg.sv]
// shared types and constants for the pattern scanner
// no dependencies
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int SH_W        = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 6;
  localparam int ADDR_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_0  = 3'd0,
    REG_PATTERN_1  = 3'd1,
    REG_PATTERN_2  = 3'd2,
    REG_PATTERN_3  = 3'd3,
    REG_WILDCARD   = 3'd4,
    REG_LENGTH     = 3'd5,
    REG_BASE       = 3'd6
  } wbps_reg_idx_t;

  typedef logic [WIN_DEPTH-1:0][7:0] wbps_win_t;

  typedef struct packed {
    logic [3:0][63:0]   pattern;
    logic [31:0]        wildcard_mask;
    logic [LEN_W-1:0]   pattern_length;
    logic [ADDR_W-1:0]  region_base;
  } wbps_cfg_t;

  // register values after reset: all zero but a length of one
  localparam wbps_cfg_t CFG_RESET = '{
    pattern:        '0,
    wildcard_mask:  '0,
    pattern_length: LEN_W'(1),
    region_base:    '0
  };

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] start_addr;
  } wbps_match_t;

endpackage

`default_nettype wire

[rtl/wbps_in_if.sv]
// input channel: one region byte per word
// depends on nothing
`default_nettype none

interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_region;

  modport source (output valid, output data_byte, output last_in_region, input ready);
  modport sink   (input valid, input data_byte, input last_in_region, output ready);
endinterface

`default_nettype wire

[rtl/wbps_out_if.sv]
// result channel: one word per region
// depends on nothing
`default_nettype none

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

[rtl/wbps_cfg_regs.sv]
// configuration register file of the pattern scanner
// depends on wbps_pkg
`default_nettype none

module wbps_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output wbps_pkg::wbps_cfg_t                   cfg
);

  wbps_pkg::wbps_cfg_t cfg_r;
  wbps_pkg::wbps_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (wbps_pkg::wbps_reg_idx_t'(cfg_index))
        wbps_pkg::REG_PATTERN_0: cfg_nxt.pattern[0] = cfg_wdata;
        wbps_pkg::REG_PATTERN_1: cfg_nxt.pattern[1] = cfg_wdata;
        wbps_pkg::REG_PATTERN_2: cfg_nxt.pattern[2] = cfg_wdata;
        wbps_pkg::REG_PATTERN_3: cfg_nxt.pattern[3] = cfg_wdata;
        wbps_pkg::REG_WILDCARD:  cfg_nxt.wildcard_mask = cfg_wdata[31:0];
        wbps_pkg::REG_LENGTH:    cfg_nxt.pattern_length = cfg_wdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_BASE:      cfg_nxt.region_base = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= wbps_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/wbps_window.sv]
// byte history, byte count and reported flag of the current region
// depends on wbps_pkg
`default_nettype none

module wbps_window (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire logic [7:0]                     cur_byte,
  input  wire logic                           cur_last,
  input  wire logic                           hit,
  output wbps_pkg::wbps_win_t                 window,
  output logic [wbps_pkg::ADDR_W-1:0]         bytes_seen,
  output logic                                reported
);

  wbps_pkg::wbps_win_t               window_r, window_nxt;
  logic [wbps_pkg::ADDR_W-1:0]       seen_r, seen_nxt;
  logic                              reported_r, reported_nxt;

  always_comb begin
    window_nxt   = window_r;
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (advance) begin
      if (cur_last) begin
        window_nxt   = '0;
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else begin
        for (int k = wbps_pkg::WIN_DEPTH - 1; k > 0; k--) begin
          window_nxt[k] = window_r[k-1];
        end
        window_nxt[0] = cur_byte;
        seen_nxt      = seen_r + wbps_pkg::ADDR_W'(1);
        reported_nxt  = reported_r | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '0;
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else begin
      window_r   <= window_nxt;
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
    end
  end

  assign window     = window_r;
  assign bytes_seen = seen_r;
  assign reported   = reported_r;

endmodule

`default_nettype wire

[rtl/wbps_match.sv]
// parallel masked compare of the byte window against the pattern
// depends on wbps_pkg
`default_nettype none

module wbps_match (
  input  wire wbps_pkg::wbps_cfg_t            cfg,
  input  wire wbps_pkg::wbps_win_t            window,
  input  wire logic [wbps_pkg::ADDR_W-1:0]    bytes_seen,
  input  wire logic                           reported,
  input  wire logic [7:0]                     cur_byte,
  output wbps_pkg::wbps_match_t               result
);

  localparam int PW = 8 * wbps_pkg::MAX_PATTERN;

  logic [wbps_pkg::LEN_W-1:0]         len_eff;
  logic [wbps_pkg::LEN_W-1:0]         len_m1;
  logic [wbps_pkg::SH_W-1:0]          shamt;
  logic [PW-1:0]                      pat_flat;
  logic [PW-1:0]                      rev_pat;
  logic [PW-1:0]                      al_pat;
  logic [wbps_pkg::MAX_PATTERN-1:0]   rev_wild;
  logic [wbps_pkg::MAX_PATTERN-1:0]   al_wild;
  logic [wbps_pkg::MAX_PATTERN-1:0]   mism;
  logic [wbps_pkg::MAX_PATTERN-1:0][7:0] cand;
  logic                               seen_ok;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = wbps_pkg::LEN_W'(1);
    end else if (cfg.pattern_length > wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN)) begin
      len_eff = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
    end else begin
      len_eff = cfg.pattern_length;
    end
    len_m1 = len_eff - wbps_pkg::LEN_W'(1);
    // candidate k (window slot k-1, or the current byte for k=0) needs pattern position len-1-k
    shamt  = wbps_pkg::SH_W'(wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN) - len_eff);
  end

  assign pat_flat = PW'({cfg.pattern[3], cfg.pattern[2], cfg.pattern[1], cfg.pattern[0]});

  always_comb begin
    for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++) begin
      rev_pat[8*j +: 8] = pat_flat[8*(wbps_pkg::MAX_PATTERN-1-j) +: 8];
      rev_wild[j]       = cfg.wildcard_mask[wbps_pkg::MAX_PATTERN-1-j];
    end
  end

  assign al_pat  = rev_pat >> {shamt, 3'b000};
  assign al_wild = rev_wild >> shamt;

  always_comb begin
    cand[0] = cur_byte;
    for (int k = 1; k < wbps_pkg::MAX_PATTERN; k++) begin
      cand[k] = window[k-1];
    end
    for (int k = 0; k < wbps_pkg::MAX_PATTERN; k++) begin
      mism[k] = (wbps_pkg::LEN_W'(k) < len_eff) && !al_wild[k] &&
                (cand[k] != al_pat[8*k +: 8]);
    end
  end

  assign seen_ok = (|bytes_seen[wbps_pkg::ADDR_W-1:wbps_pkg::SH_W]) ||
                   (wbps_pkg::LEN_W'(bytes_seen[wbps_pkg::SH_W-1:0]) >= len_m1);

  assign result.hit        = !reported && seen_ok && !(|mism);
  assign result.start_addr = cfg.region_base + bytes_seen - wbps_pkg::ADDR_W'(len_m1);

endmodule

`default_nettype wire

[rtl/wildcard_byte_pattern_scanner_core.sv]
// top level of the wildcard byte pattern scanner
// depends on wbps_pkg, wbps_in_if, wbps_out_if, wbps_cfg_regs, wbps_window, wbps_match
//
//   port      | dir    | word
//   ----------+--------+-----------------------------------------
//   in_chan   | sink   | data_byte, last_in_region
//   out_chan  | source | found, match_address
//   cfg_*     | write  | cfg_we, cfg_index, cfg_wdata
//
// one byte per cycle unless a held result stalls it: the byte sits in an input register, the compare
// of all 31 window slots and the current byte, and the start address add, feed the result register
// a result word is valid in the cycle after its byte leaves the input register
// a held result stalls only a byte that has its own result to give
// synchronous active-low reset clears window, count and both valid flags
`default_nettype none

`include "wildcard_byte_pattern_scanner_core_assert.svh"

module wildcard_byte_pattern_scanner_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  wbps_in_if.sink                               in_chan,
  wbps_out_if.source                            out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  wbps_pkg::wbps_cfg_t            cfg;
  wbps_pkg::wbps_win_t            window;
  wbps_pkg::wbps_match_t          mres;
  logic [wbps_pkg::ADDR_W-1:0]    bytes_seen;
  logic                           reported;

  logic                           s1_valid_r, s1_valid_nxt;
  logic [7:0]                     s1_byte_r;
  logic                           s1_last_r;
  logic                           out_valid_r, out_valid_nxt;
  logic                           found_r;
  logic [wbps_pkg::ADDR_W-1:0]    addr_r;

  logic                           s1_res;
  logic                           out_free;
  logic                           advance;
  logic                           in_fire;

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbps_window u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .cur_byte   (s1_byte_r),
    .cur_last   (s1_last_r),
    .hit        (mres.hit),
    .window     (window),
    .bytes_seen (bytes_seen),
    .reported   (reported)
  );

  wbps_match u_match (
    .cfg        (cfg),
    .window     (window),
    .bytes_seen (bytes_seen),
    .reported   (reported),
    .cur_byte   (s1_byte_r),
    .result     (mres)
  );

  // a byte gives a word on a hit, or as a not-found at the end of a region with no hit reported
  assign s1_res   = mres.hit || (s1_last_r && !reported);
  assign out_free = !out_valid_r || out_chan.ready;
  assign advance  = s1_valid_r && (!s1_res || out_free);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && s1_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_in_region;
    end
    if (advance && s1_res) begin
      found_r <= mres.hit;
      addr_r  <= mres.hit ? mres.start_addr : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.found         = found_r;
  assign out_chan.match_address = addr_r;

  `WBPS_ASSERT_NOW(a_notfound_zero_addr, out_valid_r && !found_r, addr_r == '0)
  `WBPS_ASSERT_NEXT(a_last_clears, advance && s1_last_r, bytes_seen == '0 && !reported)
  `WBPS_ASSERT_NEXT(a_result_loaded, advance && s1_res, out_valid_r)
  `WBPS_ASSERT_NOW(a_no_hit_after_report, reported, !mres.hit)

endmodule

`default_nettype wire
